// ===== rtl/core/dtcsm_pkg.sv =====
package dtcsm_pkg;

  // action codes
  localparam logic [2:0] ACT_SET_CODE = 3'd0;
  localparam logic [2:0] ACT_TEST     = 3'd1;
  localparam logic [2:0] ACT_FORCE    = 3'd2;
  localparam logic [2:0] ACT_CLEAR    = 3'd3;
  localparam logic [2:0] ACT_READ     = 3'd4;
  localparam logic [2:0] ACT_COUNT    = 3'd5;

  // test result codes
  localparam logic [1:0] RES_PASSED = 2'd0;
  localparam logic [1:0] RES_FAILED = 2'd1;

  // status byte bits
  localparam logic [7:0] ST_TF     = 8'h01;
  localparam logic [7:0] ST_TFTMC  = 8'h02;
  localparam logic [7:0] ST_PDTC   = 8'h04;
  localparam logic [7:0] ST_CDTC   = 8'h08;
  localparam logic [7:0] ST_TNCSLC = 8'h10;
  localparam logic [7:0] ST_TFSLC  = 8'h20;
  localparam logic [7:0] ST_TNCTMC = 8'h40;
  localparam logic [7:0] ST_WIR    = 8'h80;
  localparam logic [7:0] ST_INIT   = 8'h50;

  // register indexes
  localparam logic [2:0] REG_UPDATE_ENABLE = 3'd0;
  localparam logic [2:0] REG_FAIL_STEP     = 3'd1;
  localparam logic [2:0] REG_FAULT_MAX     = 3'd2;
  localparam logic [2:0] REG_CONFIRM_THR   = 3'd3;
  localparam logic [2:0] REG_DEBOUNCE      = 3'd4;
  localparam logic [2:0] REG_AGING_MAX     = 3'd5;
  localparam logic [2:0] REG_AGING_STEP    = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       update_enable;
    logic [7:0] fail_step;
    logic [15:0] fault_max;
    logic [15:0] confirm_threshold;
    logic [7:0] debounce_cycles;
    logic [7:0] aging_max;
    logic [7:0] aging_step;
  } cfg_t;

  // one table entry
  typedef struct packed {
    logic [23:0] code;
    logic [7:0]  status;
    logic [15:0] fault_count;
    logic [7:0]  debounce;
    logic [7:0]  aging;
    logic [7:0]  occurrences;
    logic [7:0]  since_clear;
    logic [3:0]  slot;
  } entry_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  status_byte;
    logic [15:0] fault_counter;
    logic [7:0]  aging_count;
    logic [7:0]  occurrences;
    logic [7:0]  occurrences_since_clear;
    logic        newly_confirmed;
    logic        snapshot_slot;
    logic [3:0]  match_count;
  } result_t;

endpackage

// ===== rtl/core/dtcsm_entry_unit.sv =====
// shared entry update unit: applies one action to one entry
module dtcsm_entry_unit #(
  parameter int SNAPSHOT_SLOTS = 2
) (
  input  dtcsm_pkg::cfg_t   cfg,
  input  logic [2:0]        action,
  input  logic [1:0]        test_result,
  input  logic [23:0]       lookup_code,
  input  logic [23:0]       group_mask,
  input  logic [7:0]        count_mask,
  input  dtcsm_pkg::entry_t ent,
  output dtcsm_pkg::entry_t ent_next,
  output logic              hit,
  output logic              newly,
  output logic              snap_bit
);

  localparam logic [3:0] SLOT_LAST = 4'(SNAPSHOT_SLOTS - 1);

  logic [7:0]  st;
  logic [16:0] fsum;
  logic [8:0]  asum;
  logic [15:0] fc;
  logic [7:0]  db;
  logic        nonempty;

  always_comb begin
    ent_next = ent;
    hit      = 1'b0;
    newly    = 1'b0;
    snap_bit = 1'b0;
    st       = ent.status;
    fsum     = '0;
    asum     = '0;
    fc       = ent.fault_count;
    db       = ent.debounce;
    nonempty = (ent.code != '0);
    unique case (action)
      dtcsm_pkg::ACT_SET_CODE: ent_next.code = lookup_code;
      dtcsm_pkg::ACT_FORCE: begin
        if (nonempty) begin
          ent_next.status = (st | dtcsm_pkg::ST_CDTC | dtcsm_pkg::ST_TF |
                             dtcsm_pkg::ST_TFSLC | dtcsm_pkg::ST_TFTMC) &
                            ~(dtcsm_pkg::ST_TNCSLC | dtcsm_pkg::ST_TNCTMC);
          ent_next.occurrences = ent.occurrences + 8'd1;
          ent_next.since_clear = ent.since_clear + 8'd1;
        end
      end
      dtcsm_pkg::ACT_TEST: begin
        if (nonempty) begin
          if (!cfg.update_enable) begin
            if (test_result == dtcsm_pkg::RES_FAILED) st = st | dtcsm_pkg::ST_TFTMC;
            ent_next.status = st & ~dtcsm_pkg::ST_TNCTMC;
          end else if (test_result == dtcsm_pkg::RES_PASSED) begin
            // passed: count down and age confirmed faults
            st = st & ~(dtcsm_pkg::ST_TF | dtcsm_pkg::ST_TNCTMC | dtcsm_pkg::ST_TNCSLC);
            if (fc != '0) fc = fc - 16'd1;
            if ((st & dtcsm_pkg::ST_CDTC) != '0 && ent.aging < cfg.aging_max) begin
              asum = {1'b0, ent.aging} + {1'b0, cfg.aging_step};
              if (asum[8]) asum = 9'd255;
              ent_next.aging = asum[7:0];
              if (asum[7:0] >= cfg.aging_max) begin
                st = st & ~(dtcsm_pkg::ST_CDTC | dtcsm_pkg::ST_WIR);
                fc = '0;
              end
            end
            ent_next.fault_count = fc;
            ent_next.status      = st;
          end else if (test_result == dtcsm_pkg::RES_FAILED) begin
            // failed: count up, debounce, confirm
            st = (st | dtcsm_pkg::ST_TF | dtcsm_pkg::ST_TFTMC | dtcsm_pkg::ST_TFSLC) &
                 ~(dtcsm_pkg::ST_TNCTMC | dtcsm_pkg::ST_TNCSLC);
            if (fc < cfg.fault_max) begin
              fsum = {1'b0, fc} + {9'd0, cfg.fail_step};
              fc   = fsum[16] ? 16'hFFFF : fsum[15:0];
            end
            if ((st & dtcsm_pkg::ST_PDTC) == '0) begin
              if (db != 8'hFF) db = db + 8'd1;
              if (db >= cfg.debounce_cycles) begin
                st = st | dtcsm_pkg::ST_PDTC;
                db = cfg.debounce_cycles;
              end
            end
            if (fc >= cfg.confirm_threshold) begin
              if ((st & dtcsm_pkg::ST_CDTC) == '0) begin
                newly    = 1'b1;
                snap_bit = ent.slot[0];
                ent_next.slot = (ent.slot >= SLOT_LAST) ? 4'd0 : ent.slot + 4'd1;
                st = st | dtcsm_pkg::ST_CDTC | dtcsm_pkg::ST_WIR;
                ent_next.occurrences = ent.occurrences + 8'd1;
                ent_next.since_clear = ent.since_clear + 8'd1;
              end
              ent_next.aging = '0;
            end
            ent_next.fault_count = fc;
            ent_next.debounce    = db;
            ent_next.status      = st;
          end
        end
      end
      dtcsm_pkg::ACT_CLEAR: begin
        if (nonempty && (ent.code & group_mask) != '0) begin
          hit = 1'b1;
          ent_next.status      = dtcsm_pkg::ST_INIT;
          ent_next.debounce    = '0;
          ent_next.fault_count = '0;
          ent_next.since_clear = '0;
          ent_next.aging       = '0;
        end
      end
      dtcsm_pkg::ACT_READ: hit = (lookup_code != '0) && (ent.code == lookup_code);
      dtcsm_pkg::ACT_COUNT: hit = nonempty && ((ent.status & count_mask) != '0);
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/dtc_status_manager_core.sv =====
// DTC status manager core
// Input channel (valid/ready) carries one action item: action, entry_index,
// lookup_code, test_result, group_mask, count_mask. Output channel (valid/ready)
// returns one result item per input item.
// Table rows are visited one per cycle through a single shared entry update
// unit under a small sequencer. Single-entry actions pass from accept through
// the update state to the done state; clear and count sweep all entries in the
// scan state; read stops at the first matching entry or sweeps all entries
// when nothing matches. One item is in flight at a time and the block returns
// to idle in the cycle after the result is taken, so a new item is accepted
// only once the previous result has been taken.
// The result sits in an output register; while the receiver stalls the block
// holds it and accepts no new item until it is taken.
// Reset (synchronous, rst high) empties all entries, sets status bytes to
// 0x50, zeroes the counters and loads the register defaults, all at once.
// The user must write the configuration registers over the APB port only while
// idle; the block itself does not enforce it. Registers at byte addresses 0..24, step 4.
module dtc_status_manager_core #(
  parameter int ENTRIES        = 8,
  parameter int SNAPSHOT_SLOTS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [2:0]  entry_index,
  input  logic [23:0] lookup_code,
  input  logic [1:0]  test_result,
  input  logic [23:0] group_mask,
  input  logic [7:0]  count_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [7:0]  status_byte,
  output logic [15:0] fault_counter,
  output logic [7:0]  aging_count,
  output logic [7:0]  occurrences,
  output logic [7:0]  occurrences_since_clear,
  output logic        newly_confirmed,
  output logic        snapshot_slot,
  output logic [3:0]  match_count
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW:0] LAST = (IW + 1)'(ENTRIES - 1);

  dtcsm_pkg::cfg_t   cfg;
  dtcsm_pkg::entry_t table_q [ENTRIES];
  dtcsm_pkg::state_t state, state_next;
  dtcsm_pkg::result_t res;

  logic [2:0]  act_q;
  logic [2:0]  idx_q;
  logic [23:0] code_q, grp_q;
  logic [1:0]  tres_q;
  logic [7:0]  smask_q;
  logic [IW:0] ptr;
  logic        idx_ok;

  dtcsm_pkg::entry_t cur, upd;
  logic hit, newly, snap_bit;

  assign pready   = 1'b1;
  assign in_ready = (state == dtcsm_pkg::S_IDLE);
  assign idx_ok   = ({4'd0, idx_q} < 7'(ENTRIES));

  // entry under work
  assign cur = table_q[ptr[IW-1:0]];

  dtcsm_entry_unit #(.SNAPSHOT_SLOTS(SNAPSHOT_SLOTS)) u_unit (
    .cfg(cfg), .action(act_q), .test_result(tres_q), .lookup_code(code_q),
    .group_mask(grp_q), .count_mask(smask_q), .ent(cur), .ent_next(upd),
    .hit(hit), .newly(newly), .snap_bit(snap_bit)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.update_enable     <= 1'b1;
      cfg.fail_step         <= 8'd2;
      cfg.fault_max         <= 16'd127;
      cfg.confirm_threshold <= 16'd6;
      cfg.debounce_cycles   <= 8'd3;
      cfg.aging_max         <= 8'd40;
      cfg.aging_step        <= 8'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        dtcsm_pkg::REG_UPDATE_ENABLE: cfg.update_enable     <= pwdata[0];
        dtcsm_pkg::REG_FAIL_STEP:     cfg.fail_step         <= pwdata[7:0];
        dtcsm_pkg::REG_FAULT_MAX:     cfg.fault_max         <= pwdata[15:0];
        dtcsm_pkg::REG_CONFIRM_THR:   cfg.confirm_threshold <= pwdata[15:0];
        dtcsm_pkg::REG_DEBOUNCE:      cfg.debounce_cycles   <= pwdata[7:0];
        dtcsm_pkg::REG_AGING_MAX:     cfg.aging_max         <= pwdata[7:0];
        dtcsm_pkg::REG_AGING_STEP:    cfg.aging_step        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      dtcsm_pkg::REG_UPDATE_ENABLE: prdata = {31'd0, cfg.update_enable};
      dtcsm_pkg::REG_FAIL_STEP:     prdata = {24'd0, cfg.fail_step};
      dtcsm_pkg::REG_FAULT_MAX:     prdata = {16'd0, cfg.fault_max};
      dtcsm_pkg::REG_CONFIRM_THR:   prdata = {16'd0, cfg.confirm_threshold};
      dtcsm_pkg::REG_DEBOUNCE:      prdata = {24'd0, cfg.debounce_cycles};
      dtcsm_pkg::REG_AGING_MAX:     prdata = {24'd0, cfg.aging_max};
      dtcsm_pkg::REG_AGING_STEP:    prdata = {24'd0, cfg.aging_step};
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dtcsm_pkg::S_IDLE:
        if (in_valid) begin
          if (action == dtcsm_pkg::ACT_CLEAR || action == dtcsm_pkg::ACT_READ ||
              action == dtcsm_pkg::ACT_COUNT) state_next = dtcsm_pkg::S_SCAN;
          else state_next = dtcsm_pkg::S_UPDATE;
        end
      dtcsm_pkg::S_SCAN:
        if (ptr == LAST || (act_q == dtcsm_pkg::ACT_READ && hit))
          state_next = dtcsm_pkg::S_DONE;
      dtcsm_pkg::S_UPDATE: state_next = dtcsm_pkg::S_DONE;
      dtcsm_pkg::S_DONE: if (out_ready) state_next = dtcsm_pkg::S_IDLE;
      default: state_next = dtcsm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= dtcsm_pkg::S_IDLE;
    else     state <= state_next;
  end

  // outputs of the sequencer
  assign out_valid = (state == dtcsm_pkg::S_DONE);

  // item capture, sweep pointer and result
  always_ff @(posedge clk) begin
    if (state == dtcsm_pkg::S_IDLE && in_valid) begin
      act_q   <= action;
      idx_q   <= entry_index;
      code_q  <= lookup_code;
      tres_q  <= test_result;
      grp_q   <= group_mask;
      smask_q <= count_mask;
      res     <= '0;
      if (action == dtcsm_pkg::ACT_CLEAR || action == dtcsm_pkg::ACT_READ ||
          action == dtcsm_pkg::ACT_COUNT) ptr <= '0;
      else ptr <= (IW + 1)'(entry_index);
    end else if (state == dtcsm_pkg::S_SCAN) begin
      ptr <= ptr + 1'b1;
      if (hit) begin
        if (act_q == dtcsm_pkg::ACT_READ) begin
          res.found                   <= 1'b1;
          res.status_byte             <= cur.status;
          res.fault_counter           <= cur.fault_count;
          res.aging_count             <= cur.aging;
          res.occurrences             <= cur.occurrences;
          res.occurrences_since_clear <= cur.since_clear;
        end else if (res.match_count != 4'd15) begin
          res.match_count <= res.match_count + 4'd1;
        end
      end
    end else if (state == dtcsm_pkg::S_UPDATE) begin
      if (idx_ok && act_q <= dtcsm_pkg::ACT_FORCE) begin
        res.status_byte             <= upd.status;
        res.fault_counter           <= upd.fault_count;
        res.aging_count             <= upd.aging;
        res.occurrences             <= upd.occurrences;
        res.occurrences_since_clear <= upd.since_clear;
        res.newly_confirmed         <= newly;
        res.snapshot_slot           <= snap_bit;
      end
    end
  end

  // table write back through the shared unit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        table_q[i] <= '{status: dtcsm_pkg::ST_INIT, default: '0};
      end
    end else if ((state == dtcsm_pkg::S_UPDATE && idx_ok && act_q <= dtcsm_pkg::ACT_FORCE) ||
                 (state == dtcsm_pkg::S_SCAN && act_q == dtcsm_pkg::ACT_CLEAR)) begin
      table_q[ptr[IW-1:0]] <= upd;
    end
  end

  assign found                   = res.found;
  assign status_byte             = res.status_byte;
  assign fault_counter           = res.fault_counter;
  assign aging_count             = res.aging_count;
  assign occurrences             = res.occurrences;
  assign occurrences_since_clear = res.occurrences_since_clear;
  assign newly_confirmed         = res.newly_confirmed;
  assign snapshot_slot           = res.snapshot_slot;
  assign match_count             = res.match_count;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid |-> !in_ready)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready |=> out_valid && $stable(match_count)))
    else $error("result dropped under stall");
  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found |-> match_count == 4'd0 && !newly_confirmed))
    else $error("read result mixed with other fields");
`endif

endmodule
